// ===== sv/kdlr_pkg.sv =====
package kdlr_pkg;

  localparam int KEY_W       = 4;
  localparam int TIME_W      = 32;
  localparam int PERIOD_W    = 16;
  localparam int EV_W        = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_FIELDS_W = KEY_W + TIME_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = KEY_W + EV_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [PERIOD_W-1:0] DEBOUNCE_RST = PERIOD_W'(20);
  localparam logic [PERIOD_W-1:0] LONG_RST     = PERIOD_W'(1000);
  localparam logic [PERIOD_W-1:0] REPEAT_RST   = PERIOD_W'(200);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_LONG     = 2'd1,
    CFG_REPEAT   = 2'd2
  } cfg_idx_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE   = 3'd0,
    EV_IDLE   = 3'd1,
    EV_PRESS  = 3'd2,
    EV_LONG   = 3'd3,
    EV_REPEAT = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    PH_WAIT     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_PRESS    = 3'd2,
    PH_HOLD     = 3'd3,
    PH_LONG     = 3'd4,
    PH_REPEAT   = 3'd5,
    PH_REP_SHOW = 3'd6
  } phase_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
  } poll_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] debounce;
    logic [PERIOD_W-1:0] long_hold;
    logic [PERIOD_W-1:0] repeat_gap;
  } cfg_t;

endpackage

// ===== sv/kdlr_cfg.sv =====
module kdlr_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [kdlr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kdlr_pkg::PERIOD_W-1:0]  cfg_data,
  output kdlr_pkg::cfg_t               cfg
);
  import kdlr_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE: cfg_nxt.debounce   = cfg_data;
        CFG_LONG:     cfg_nxt.long_hold  = cfg_data;
        CFG_REPEAT:   cfg_nxt.repeat_gap = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce   <= DEBOUNCE_RST;
      cfg_r.long_hold  <= LONG_RST;
      cfg_r.repeat_gap <= REPEAT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== sv/kdlr_in_reg.sv =====
module kdlr_in_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [kdlr_pkg::KEY_W-1:0]  in_key,
  input  logic [kdlr_pkg::TIME_W-1:0] in_now,
  output logic                       poll_valid,
  input  logic                       poll_take,
  output kdlr_pkg::poll_t            poll
);
  import kdlr_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  poll_t poll_r;

  assign in_ready   = !valid_r || poll_take;
  assign poll_valid = valid_r;
  assign poll       = poll_r;

  always_comb begin
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (poll_take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      poll_r.key <= in_key;
      poll_r.now <= in_now;
    end
  end

endmodule

// ===== sv/kdlr_fsm.sv =====
module kdlr_fsm (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      poll_valid,
  output logic                      poll_take,
  input  kdlr_pkg::poll_t           poll,
  input  kdlr_pkg::cfg_t            cfg,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic [kdlr_pkg::KEY_W-1:0] res_code,
  output logic [kdlr_pkg::EV_W-1:0]  res_event
);
  import kdlr_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [KEY_W-1:0]    latched_r, latched_nxt;
  logic [TIME_W-1:0]   start_r, start_nxt;
  logic [KEY_W-1:0]    code_r, code_nxt;
  event_t              event_r, event_nxt;
  logic                valid_r;
  logic                step;
  logic [TIME_W-1:0]   elapsed;
  logic [PERIOD_W-1:0] period;
  logic                time_up;
  logic                key_down;

  assign poll_take = !valid_r || res_ready;
  assign step      = poll_valid && poll_take;
  assign res_valid = valid_r;
  assign res_code  = code_r;
  assign res_event = event_r;
  assign key_down  = (poll.key != '0);

  // wrap-safe elapsed time against the period of the current phase
  assign elapsed = poll.now - start_r;

  always_comb begin
    unique case (phase_r)
      PH_DEBOUNCE: period = cfg.debounce;
      PH_HOLD:     period = cfg.long_hold;
      default:     period = cfg.repeat_gap;
    endcase
  end

  assign time_up = (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, period});

  // next phase
  always_comb begin
    unique case (phase_r)
      PH_WAIT:     phase_nxt = key_down ? PH_DEBOUNCE : PH_WAIT;
      PH_DEBOUNCE: begin
        if (!time_up) begin
          phase_nxt = PH_DEBOUNCE;
        end else begin
          phase_nxt = key_down ? PH_PRESS : PH_WAIT;
        end
      end
      PH_PRESS:    phase_nxt = PH_HOLD;
      PH_HOLD: begin
        if (poll.key != code_r) begin
          phase_nxt = PH_WAIT;
        end else begin
          phase_nxt = time_up ? PH_LONG : PH_HOLD;
        end
      end
      PH_LONG:     phase_nxt = PH_REPEAT;
      PH_REPEAT: begin
        if (!key_down) begin
          phase_nxt = PH_WAIT;
        end else begin
          phase_nxt = time_up ? PH_REP_SHOW : PH_REPEAT;
        end
      end
      PH_REP_SHOW: phase_nxt = PH_REPEAT;
      default:     phase_nxt = PH_WAIT;
    endcase
  end

  // result and timer updates
  always_comb begin
    latched_nxt = latched_r;
    start_nxt   = start_r;
    code_nxt    = code_r;
    event_nxt   = event_r;
    unique case (phase_r)
      PH_WAIT: begin
        if (key_down) begin
          start_nxt = poll.now;
        end
      end
      PH_DEBOUNCE: begin
        if (time_up) begin
          start_nxt = poll.now;
          if (key_down) begin
            latched_nxt = poll.key;
            code_nxt    = poll.key;
            event_nxt   = EV_PRESS;
          end else begin
            code_nxt  = '0;
            event_nxt = EV_NONE;
          end
        end
      end
      PH_PRESS, PH_LONG, PH_REP_SHOW: begin
        code_nxt  = latched_r;
        event_nxt = EV_IDLE;
      end
      PH_HOLD: begin
        if (poll.key != code_r) begin
          code_nxt  = '0;
          event_nxt = EV_NONE;
        end else if (time_up) begin
          start_nxt = poll.now;
          code_nxt  = latched_r;
          event_nxt = EV_LONG;
        end
      end
      PH_REPEAT: begin
        if (!key_down) begin
          code_nxt  = '0;
          event_nxt = EV_NONE;
        end else if (time_up) begin
          start_nxt = poll.now;
          code_nxt  = latched_r;
          event_nxt = EV_REPEAT;
        end
      end
      default: begin
        code_nxt  = '0;
        event_nxt = EV_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      latched_r <= '0;
      start_r   <= '0;
      code_r    <= '0;
      event_r   <= EV_NONE;
      valid_r   <= 1'b0;
    end else begin
      if (step) begin
        phase_r   <= phase_nxt;
        latched_r <= latched_nxt;
        start_r   <= start_nxt;
        code_r    <= code_nxt;
        event_r   <= event_nxt;
        valid_r   <= 1'b1;
      end else if (res_ready) begin
        valid_r   <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/key_debounce_long_repeat_fsm.sv =====
// an input transfer is held in the input register, and its result is registered in the FSM result register
// throughput: one poll per cycle while out_tready is high, set by the single state update per poll
// a stalled result lets one more poll into the input register, then in_tready drops
// config writes are taken every cycle and apply from the next poll
// rst_n is synchronous: state, timer and outputs clear, periods reload 20/1000/200
module key_debounce_long_repeat_fsm (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [kdlr_pkg::IN_TDATA_W-1:0]   in_tdata,   // raw_key, now_ms, zero pad
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [kdlr_pkg::OUT_TDATA_W-1:0]  out_tdata,  // key_code, key_event, zero pad
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kdlr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kdlr_pkg::PERIOD_W-1:0]     cfg_data
);
  import kdlr_pkg::*;

  cfg_t             cfg;
  poll_t            poll;
  logic             poll_valid;
  logic             poll_take;
  logic [KEY_W-1:0] res_code;
  logic [EV_W-1:0]  res_event;

  kdlr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kdlr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_key     (in_tdata[KEY_W-1:0]),
    .in_now     (in_tdata[KEY_W +: TIME_W]),
    .poll_valid (poll_valid),
    .poll_take  (poll_take),
    .poll       (poll)
  );

  kdlr_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .poll_valid (poll_valid),
    .poll_take  (poll_take),
    .poll       (poll),
    .cfg        (cfg),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_code   (res_code),
    .res_event  (res_event)
  );

  assign out_tdata = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, res_event, res_code};

endmodule

// ===== sv/kdlr_checker.sv =====
module kdlr_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [kdlr_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import kdlr_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no key shown exactly when the event is none
  a_code_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[KEY_W-1:0] == '0) ==
                    (out_tdata[KEY_W +: EV_W] == EV_NONE)))
    else $error("key code and event disagree");

  // an empty output side never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind key_debounce_long_repeat_fsm kdlr_checker u_kdlr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import kdlr_pkg::*;

  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [KEY_W-1:0] code;
    event_t           ev;
  } key_report_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  cfg_idx_t               cfg_index = CFG_DEBOUNCE;
  logic [PERIOD_W-1:0]    cfg_data = '0;

  // predicted block state
  phase_t              key_phase = PH_WAIT;
  logic [KEY_W-1:0]    accepted_key = '0;
  logic [TIME_W-1:0]   interval_start = '0;
  logic [KEY_W-1:0]    shown_code = '0;
  event_t              shown_event = EV_NONE;
  logic [PERIOD_W-1:0] debounce_ms = DEBOUNCE_RST;
  logic [PERIOD_W-1:0] long_ms = LONG_RST;
  logic [PERIOD_W-1:0] repeat_ms = REPEAT_RST;

  key_report_t       expected_reports[$];
  logic [TIME_W-1:0] clock_ms = '0;
  int                idle_pct = 0;
  int                stall_pct = 0;
  logic              hold_out = 1'b0;
  int                polls_sent = 0;
  int                reports_seen = 0;
  int                mismatches = 0;
  int                presses = 0;
  int                long_presses = 0;
  int                repeats = 0;

  key_debounce_long_repeat_fsm DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic key_report_t debounce_step(input logic [KEY_W-1:0] key,
                                                input logic [TIME_W-1:0] stamp);
    logic [TIME_W-1:0] elapsed;
    elapsed = stamp - interval_start;
    case (key_phase)
      PH_WAIT: begin
        if (key != '0) begin
          key_phase = PH_DEBOUNCE;
          interval_start = stamp;
        end
      end
      PH_DEBOUNCE: begin
        if (elapsed >= TIME_W'(debounce_ms)) begin
          interval_start = stamp;
          if (key != '0) begin
            key_phase = PH_PRESS;
            accepted_key = key;
            shown_code = key;
            shown_event = EV_PRESS;
          end else begin
            key_phase = PH_WAIT;
            shown_code = '0;
            shown_event = EV_NONE;
          end
        end
      end
      PH_PRESS: begin
        key_phase = PH_HOLD;
        shown_code = accepted_key;
        shown_event = EV_IDLE;
      end
      PH_HOLD: begin
        if (key == shown_code) begin
          if (elapsed >= TIME_W'(long_ms)) begin
            key_phase = PH_LONG;
            interval_start = stamp;
            shown_code = accepted_key;
            shown_event = EV_LONG;
          end
        end else begin
          key_phase = PH_WAIT;
          shown_code = '0;
          shown_event = EV_NONE;
        end
      end
      PH_LONG, PH_REP_SHOW: begin
        key_phase = PH_REPEAT;
        shown_code = accepted_key;
        shown_event = EV_IDLE;
      end
      PH_REPEAT: begin
        if (key != '0) begin
          if (elapsed >= TIME_W'(repeat_ms)) begin
            key_phase = PH_REP_SHOW;
            interval_start = stamp;
            shown_code = accepted_key;
            shown_event = EV_REPEAT;
          end
        end else begin
          key_phase = PH_WAIT;
          shown_code = '0;
          shown_event = EV_NONE;
        end
      end
      default: begin
        key_phase = PH_WAIT;
        shown_code = '0;
        shown_event = EV_NONE;
      end
    endcase
    return '{code: shown_code, ev: shown_event};
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch: %s got %0d expected %0d (result %0d)", what, got, want, reports_seen);
  endtask

  always @(posedge clk) begin : check_results
    key_report_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_reports.push_back(debounce_step(in_tdata[KEY_W-1:0],
                                                 in_tdata[KEY_W+TIME_W-1:KEY_W]));
      if (out_tvalid && out_tready) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          report_mismatch("result with nothing pending", int'(out_tdata), 0);
        end else begin
          want = expected_reports.pop_front();
          if (out_tdata[KEY_W-1:0] !== want.code)
            report_mismatch("key_code", int'(out_tdata[KEY_W-1:0]), int'(want.code));
          if (out_tdata[KEY_W+EV_W-1:KEY_W] !== want.ev)
            report_mismatch("key_event", int'(out_tdata[KEY_W+EV_W-1:KEY_W]), int'(want.ev));
          case (want.ev)
            EV_PRESS:  presses++;
            EV_LONG:   long_presses++;
            EV_REPEAT: repeats++;
            default: ;
          endcase
        end
      end
    end
  end

  always @(posedge clk)
    out_tready <= !hold_out && ($urandom_range(0, 99) >= stall_pct);

  task automatic send_poll(input logic [KEY_W-1:0] key, input logic [TIME_W-1:0] stamp);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'({stamp, key});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    polls_sent++;
  endtask

  task automatic wait_drained;
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [PERIOD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DEBOUNCE: debounce_ms = value;
      CFG_LONG:     long_ms = value;
      CFG_REPEAT:   repeat_ms = value;
      default: ;
    endcase
  endtask

  task automatic set_periods(input logic [PERIOD_W-1:0] debounce,
                             input logic [PERIOD_W-1:0] long_hold,
                             input logic [PERIOD_W-1:0] repeat_gap);
    wait_drained();
    write_reg(CFG_DEBOUNCE, debounce);
    write_reg(CFG_LONG, long_hold);
    write_reg(CFG_REPEAT, repeat_gap);
    cfg_valid <= 1'b0;
  endtask

  // one key pressed and held with random timestamp steps that may wrap and occasional glitched polls, then released
  task automatic press_and_hold;
    int                longest;
    int                step_max;
    int                polls;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  polled;
    longest = debounce_ms;
    if (long_ms > longest) longest = long_ms;
    if (repeat_ms > longest) longest = repeat_ms;
    step_max = longest / 5 + 2;
    if ($urandom_range(0, 7) == 0)
      clock_ms = $urandom;
    else if ($urandom_range(0, 7) == 0)
      clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4 * step_max);
    key = KEY_W'($urandom_range(1, 15));
    polls = $urandom_range(2, 50);
    repeat (polls) begin
      clock_ms += $urandom_range(0, step_max);
      polled = key;
      if ($urandom_range(0, 24) == 0) polled = KEY_W'($urandom_range(0, 15));
      send_poll(polled, clock_ms);
    end
    repeat ($urandom_range(1, 3)) begin
      clock_ms += $urandom_range(0, step_max);
      send_poll('0, clock_ms);
    end
  endtask

  task automatic random_traffic(input int count);
    int target;
    target = polls_sent + count;
    while (polls_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6))
          send_poll(KEY_W'($urandom_range(0, 15)), $urandom);
      end else begin
        press_and_hold();
      end
    end
  endtask

  task automatic test_reset_periods;
    idle_pct = 0;
    stall_pct = 0;
    send_poll(4'd0, 32'h0000_0000);
    send_poll(4'd0, 32'hFFFF_FFFF);
    send_poll(4'd15, 32'hFFFF_FFF0);
    send_poll(4'd15, 32'd4);
    send_poll(4'd15, 32'd5);
    send_poll(4'd15, 32'd1003);
    send_poll(4'd15, 32'd1004);
    send_poll(4'd15, 32'd1005);
    send_poll(4'd3, 32'd1203);
    send_poll(4'd3, 32'd1204);
    send_poll(4'd3, 32'd1205);
    send_poll(4'd0, 32'd1206);
  endtask

  task automatic test_key_glitches;
    // key gone when debounce ends
    send_poll(4'd1, 32'd2000);
    send_poll(4'd0, 32'd2020);
    // another key before the long press
    send_poll(4'd2, 32'd3000);
    send_poll(4'd2, 32'd3020);
    send_poll(4'd2, 32'd3021);
    send_poll(4'd5, 32'd3022);
  endtask

  task automatic test_zero_periods;
    set_periods('0, '0, '0);
    repeat (6) send_poll(4'd9, 32'd0);
    send_poll(4'd0, 32'd0);
  endtask

  task automatic test_max_periods;
    set_periods('1, '1, '1);
    idle_pct = 82;
    stall_pct = 0;
    random_traffic(225);
  endtask

  task automatic test_short_periods;
    set_periods(PERIOD_W'($urandom_range(0, 30)), PERIOD_W'($urandom_range(0, 30)),
                PERIOD_W'($urandom_range(0, 30)));
    idle_pct = 0;
    stall_pct = 82;
    random_traffic(225);
  endtask

  task automatic test_random_periods;
    set_periods(PERIOD_W'($urandom), PERIOD_W'($urandom), PERIOD_W'($urandom));
    idle_pct = 0;
    stall_pct = 0;
    random_traffic(225);
  endtask

  task automatic test_mixed_idle;
    set_periods(PERIOD_W'($urandom_range(0, 100)), PERIOD_W'($urandom_range(0, 2000)),
                PERIOD_W'($urandom_range(0, 500)));
    idle_pct = 14;
    stall_pct = 14;
    random_traffic(225);
  endtask

  task automatic test_backpressure;
    set_periods(DEBOUNCE_RST, LONG_RST, REPEAT_RST);
    idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out <= 1'b0;
      end
    join_none
    random_traffic(60);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_periods();
    test_key_glitches();
    test_zero_periods();
    test_max_periods();
    test_short_periods();
    test_random_periods();
    test_mixed_idle();
    test_backpressure();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("run: %0d polls, %0d results checked, %0d press, %0d long, %0d repeat events",
             polls_sent, reports_seen, presses, long_presses, repeats);
    $display("run: periods 0 to 65535, timestamp wrap, idle and stall mixes, %0d-cycle hold-off",
             HOLD_CYCLES);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", expected_reports.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== key_debounce_long_repeat_fsm.f =====
sv/kdlr_pkg.sv
sv/kdlr_cfg.sv
sv/kdlr_in_reg.sv
sv/kdlr_fsm.sv
sv/key_debounce_long_repeat_fsm.sv
sv/kdlr_checker.sv
test/testbench.sv
